// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker module
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/swm_pkg.sv =====
// shared constants and types of the sliding window median filter
// no dependencies
package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W      = 7;
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

    typedef logic signed [DATA_W-1:0] sample_t;

    typedef struct packed {
        logic             valid;
        logic             gt;
        logic             evict;
        sample_t          value;
        logic [IDX_W-1:0] age;
    } cell_state_t;

    typedef struct packed {
        logic             step;
        logic             clear;
        logic             flush;
        sample_t          x;
        logic [IDX_W-1:0] age_last;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/swm_if.sv =====
// stream and configuration interfaces of the sliding window median filter
// depends on swm_pkg
interface swm_in_if;
    import swm_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    start_req;
    modport source (output valid, output sample, output start_req, input ready);
    modport sink (input valid, input sample, input start_req, output ready);
endinterface

interface swm_out_if;
    import swm_pkg::*;
    logic    valid;
    logic    ready;
    sample_t median;
    modport source (output valid, output median, input ready);
    modport sink (input valid, input median, output ready);
endinterface

interface swm_cfg_if;
    import swm_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;
    modport source (output valid, output window_size, input ready);
    modport sink (input valid, input window_size, output ready);
endinterface

// ===== rtl/core/swm_cell.sv =====
// one cell of the sorted window: value, age and valid bit
// depends on swm_pkg
module swm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  swm_pkg::cell_ctrl_t ctrl,
    input  logic                ge,
    input  swm_pkg::cell_state_t left,
    input  swm_pkg::cell_state_t right,
    output swm_pkg::cell_state_t state
);
    import swm_pkg::*;

    logic             valid_reg, valid_next;
    sample_t          value_reg, value_next;
    logic [IDX_W-1:0] age_reg, age_next;
    logic             valid_eff;
    logic             gt;
    logic             r_le;

    assign valid_eff = valid_reg && !ctrl.clear;
    assign gt        = !valid_eff || (value_reg > ctrl.x);
    assign r_le      = right.valid && !right.gt;

    assign state.valid = valid_eff;
    assign state.gt    = gt;
    assign state.evict = valid_eff && (age_reg == ctrl.age_last);
    assign state.value = value_reg;
    assign state.age   = age_reg;

    always_comb
    begin
        valid_next = valid_eff;
        value_next = value_reg;
        age_next   = age_reg + IDX_W'(1);
        if (!ge)
        begin
            // before the evicted slot: shift right to open a gap and insert the new sample
            if (gt)
            begin
                if (left.gt)
                begin
                    valid_next = left.valid;
                    value_next = left.value;
                    age_next   = left.age + IDX_W'(1);
                end
                else
                begin
                    valid_next = 1'b1;
                    value_next = ctrl.x;
                    age_next   = '0;
                end
            end
        end
        else
        begin
            // at or after the evicted slot: shift left to close it or take the new sample
            if (r_le)
            begin
                valid_next = right.valid;
                value_next = right.value;
                age_next   = right.age + IDX_W'(1);
            end
            else if ((state.evict && !left.gt) || (!state.evict && !gt))
            begin
                valid_next = 1'b1;
                value_next = ctrl.x;
                age_next   = '0;
            end
            else if (state.evict)
            begin
                valid_next = left.valid;
                value_next = left.value;
                age_next   = left.age + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.flush)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

// ===== rtl/core/swm_chain.sv =====
// row of sorted cells with eviction region decode and median select
// depends on swm_pkg and swm_cell
module swm_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  swm_pkg::cell_ctrl_t ctrl,
    input  logic [swm_pkg::IDX_W-1:0] med_idx,
    output swm_pkg::sample_t    median
);
    import swm_pkg::*;

    cell_state_t             cells [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]   evict_vec;
    logic [MAX_WINDOW-1:0]   ge_vec;
    cell_state_t             edge_left;
    cell_state_t             edge_right;

    assign edge_left  = '{valid: 1'b1, gt: 1'b0, evict: 1'b0, value: '0, age: '0};
    assign edge_right = '{valid: 1'b0, gt: 1'b1, evict: 1'b0, value: '0, age: '0};

    // one-hot evict slot: ones from it upward, none when nothing leaves
    assign ge_vec = ~(evict_vec - MAX_WINDOW'(1));

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        cell_state_t l_st;
        cell_state_t r_st;
        if (i == 0)
        begin : g_first
            assign l_st = edge_left;
        end
        else
        begin : g_mid_l
            assign l_st = cells[i-1];
        end
        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign r_st = edge_right;
        end
        else
        begin : g_mid_r
            assign r_st = cells[i+1];
        end
        assign evict_vec[i] = cells[i].evict;

        swm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .ge    (ge_vec[i]),
            .left  (l_st),
            .right (r_st),
            .state (cells[i])
        );
    end

    always_comb
    begin
        median = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (med_idx == IDX_W'(i))
            begin
                median = median | cells[i].value;
            end
        end
    end

endmodule

// ===== rtl/core/sliding_window_median_top.sv =====
// sliding window lower median filter, top level
// depends on swm_pkg, swm_if and swm_chain
//
// usage:
//   din  carries one signed 32-bit sample and a start_req flag per transaction;
//        start_req empties the window before that sample is taken.
//   dout carries the lower median of the full window, one transaction per
//        input once window_size samples of the current sequence have arrived.
//   cfg  writes window_size (0 acts as 1, above 64 acts as 64); every write
//        also empties the window. cfg is always ready.
// throughput: one sample per cycle while din.ready is high; the sorted cell row
//   updates all cells in the cycle a sample is accepted and the median is read
//   into the output register once that register is free.
// stall: one result can wait in the output register while the next one waits
//   in the cell row; din.ready drops only while both are held by dout.
// reset: window_size returns to 3, the window is empty, no result is pending.
module sliding_window_median_top (
    input logic clk,
    input logic rst_n,
    swm_in_if.sink    din,
    swm_out_if.source dout,
    swm_cfg_if.sink   cfg
);
    import swm_pkg::*;

    logic [CFG_W-1:0] window_size_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    sample_t          median_reg;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] fill_eff;
    logic [CNT_W-1:0] fill_inc;
    logic             accept;
    logic             cfg_wr;
    logic             emit;
    logic             load_out;
    cell_ctrl_t       ctrl;
    logic [IDX_W-1:0] med_idx;
    sample_t          chain_median;

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k = CNT_W'(1);
        end
        else if (window_size_reg > CFG_W'(MAX_WINDOW))
        begin
            k = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            k = CNT_W'(window_size_reg);
        end
    end

    assign med_idx  = IDX_W'((k - CNT_W'(1)) >> 1);
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign din.ready = !(pend_reg && out_valid_reg && !dout.ready);
    assign accept    = din.valid && din.ready;
    assign load_out  = pend_reg && (!out_valid_reg || dout.ready);

    assign fill_eff = din.start_req ? '0 : fill_reg;
    assign fill_inc = fill_eff + CNT_W'(1);
    assign emit     = (fill_eff == k) || (fill_inc == k);

    assign ctrl.step     = accept;
    assign ctrl.clear    = accept && din.start_req;
    assign ctrl.flush    = cfg_wr;
    assign ctrl.x        = din.sample;
    assign ctrl.age_last = IDX_W'(k - CNT_W'(1));

    swm_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .med_idx (med_idx),
        .median  (chain_median)
    );

    always_comb
    begin
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (dout.valid && dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            pend_next      = 1'b0;
        end
        if (accept)
        begin
            fill_next = (fill_eff == k) ? k : fill_inc;
            pend_next = emit;
        end
        if (cfg_wr)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_RESET;
            fill_reg        <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                window_size_reg <= cfg.window_size;
            end
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            median_reg <= chain_median;
        end
    end

    assign dout.valid  = out_valid_reg;
    assign dout.median = median_reg;

endmodule

// ===== rtl/core/swm_checker.sv =====
// port-level checks of the sliding window median filter, bound to the top
// depends on assert_macros.svh and sliding_window_median_top
`include "assert_macros.svh"

module swm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // result stays offered until taken
    `SWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // a new result follows an earlier input transaction
    `SWM_ASSERT_IMPL(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2))
    // input stalls only while the output is backed up
    `SWM_ASSERT_IMPL(a_in_stall, !in_ready, out_valid && !out_ready)

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready)
);
